// ===== rtl/sha256_pkg.sv =====
package sha256_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned LengthPos  = 56;

	localparam logic [7:0] PadByte = 8'h80;

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
		32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
		32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
		32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
		32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
		32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
		32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
		32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
		32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

endpackage

// ===== rtl/sha256_round.sv =====
// One compression round per cycle plus the rolling 16-word schedule window.
module sha256_round import sha256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] w_in,
	input  logic [31:0] h_in [8],
	output logic [31:0] h_out [8],
	output logic        busy,
	output logic        done
);

	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] st_q [8];
	logic [31:0] w_q [16];
	logic [31:0] wt, t1, t2, s0, s1;
	logic [5:0]  rnd;

	assign rnd = cnt_q[5:0];
	assign s0  = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1  = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	// first 16 rounds take message words, later ones the expanded schedule
	assign wt  = (cnt_q < 7'd16) ? w_in : (s1 + w_q[9] + s0 + w_q[0]);
	assign t1  = st_q[7] + (rotr(st_q[4], 6) ^ rotr(st_q[4], 11) ^ rotr(st_q[4], 25))
		+ ((st_q[4] & st_q[5]) ^ (~st_q[4] & st_q[6])) + RoundK[rnd] + wt;
	assign t2  = (rotr(st_q[0], 2) ^ rotr(st_q[0], 13) ^ rotr(st_q[0], 22))
		+ ((st_q[0] & st_q[1]) ^ (st_q[0] & st_q[2]) ^ (st_q[1] & st_q[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			st_q <= h_in;
		end else if (busy_q) begin
			st_q[7] <= st_q[6];
			st_q[6] <= st_q[5];
			st_q[5] <= st_q[4];
			st_q[4] <= st_q[3] + t1;
			st_q[3] <= st_q[2];
			st_q[2] <= st_q[1];
			st_q[1] <= st_q[0];
			st_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wt;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) h_out[i] = h_in[i] + st_q[i];
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// ===== rtl/sha256_hash_engine_core.sv =====
// Streaming SHA-256 core.
// A byte that does not complete a block is written to block memory; the 64th
// byte stalls input through fetch, 64 rounds one per cycle, hash update.
// No byte is taken while a block is compressed. End of message adds padding
// (one memory write per byte, up to 64 per block), one or two compressions,
// then eight digest transactions. Reset restores the initial hash.
module sha256_hash_engine_core import sha256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	input  logic        in_valid,
	output logic        in_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word,
	output logic        out_valid,
	input  logic        out_stall
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_PAD  = 7'b0000010,
		ST_LEN  = 7'b0000100,
		ST_CMP  = 7'b0001000,
		ST_WAIT = 7'b0010000,
		ST_OUT  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [60:0] count_q;
	logic        fin_q;       // message ended, 0x80 pad byte still to write
	logic        last_blk_q;  // current compression is the final one
	logic        pad_more_q;  // pad overflow block in flight, length block follows
	logic [31:0] hash_q [8];
	logic [31:0] h_new [8];
	logic [2:0]  oidx_q;

	// block memory, 16 words of 32 bits, byte writes
	logic [31:0] mem [16];
	logic [31:0] rd_q;
	logic [3:0]  rd_addr;
	logic        we;
	logic [5:0]  wa;
	logic [7:0]  wd;
	logic [3:0]  fetch_q;

	logic        cmp_start_q;
	logic        cmp_busy;
	logic        cmp_done;
	logic [63:0] bits;

	assign bits = {count_q, 3'b000};

	sha256_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmp_start_q),
		.w_in   (rd_q),
		.h_in   (hash_q),
		.h_out  (h_new),
		.busy   (cmp_busy),
		.done   (cmp_done)
	);

	always_ff @(posedge clk) begin
		if (we) begin
			case (wa[1:0])
				2'd0:    mem[wa[5:2]][31:24] <= wd;
				2'd1:    mem[wa[5:2]][23:16] <= wd;
				2'd2:    mem[wa[5:2]][15:8]  <= wd;
				default: mem[wa[5:2]][7:0]   <= wd;
			endcase
		end
		rd_q <= mem[rd_addr];
	end

	// word 0 is fetched until the rounds start; then the counter runs one
	// ahead so the registered read lines up with each round
	assign rd_addr = cmp_busy ? fetch_q + 4'd1 : 4'd0;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		we = 1'b0;
		wa = fill_q;
		wd = data_byte;
		case (state_q)
			ST_IDLE: we = in_valid && byte_valid;
			ST_PAD: begin
				we = 1'b1;
				wd = fin_q ? PadByte : 8'h00;
			end
			ST_LEN: begin
				we = 1'b1;
				wd = bits[6'(63 - 8 * fill_q[2:0]) -: 8];
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			count_q     <= '0;
			fin_q       <= 1'b0;
			last_blk_q  <= 1'b0;
			pad_more_q  <= 1'b0;
			oidx_q      <= '0;
			fetch_q     <= '0;
			hash_q      <= InitHash;
			cmp_start_q <= 1'b0;
		end else begin
			cmp_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (byte_valid) begin
							fill_q  <= fill_q + 6'd1;
							count_q <= count_q + 61'd1;
						end
						if (byte_valid && fill_q == 6'd63) begin
							state_q    <= ST_CMP;
							last_blk_q <= 1'b0;
							fin_q      <= end_of_message;
						end else if (end_of_message) begin
							if (byte_valid) fill_q <= fill_q + 6'd1;
							state_q <= ST_PAD;
							fin_q   <= 1'b1;
						end
					end
				end
				ST_PAD: begin
					// 0x80 first if fin_q, then zeros to the length field or the block end
					fin_q  <= 1'b0;
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						state_q    <= ST_CMP;
						last_blk_q <= 1'b0;
						pad_more_q <= 1'b1;
					end else if (fill_q == 6'(LengthPos - 1)) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						state_q    <= ST_CMP;
						last_blk_q <= 1'b1;
					end
				end
				ST_CMP: begin
					fetch_q     <= '0;
					cmp_start_q <= 1'b1;
					state_q     <= ST_WAIT;
				end
				ST_WAIT: begin
					if (cmp_busy) fetch_q <= fetch_q + 4'd1;
					if (cmp_done) begin
						hash_q <= h_new;
						fill_q <= '0;
						if (last_blk_q) begin
							state_q <= ST_OUT;
							oidx_q  <= '0;
						end else if (fin_q || pad_more_q) begin
							state_q    <= ST_PAD;
							pad_more_q <= 1'b0;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					// returned from a data block
					state_q <= ST_IDLE;
				end
				ST_OUT: begin
					if (!out_stall) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q    <= ST_IDLE;
							hash_q     <= InitHash;
							count_q    <= '0;
							fill_q     <= '0;
							last_blk_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// overflow pad block: after it, zeros up to the length field
	// (fin_q cleared, state ST_PAD writes zeros from position 0)

	assign out_valid   = (state_q == ST_OUT);
	assign digest_word = hash_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);

endmodule
